FILE: sv/mcomp_pkg.sv
`timescale 1ns / 1ps
// ============================================================================
// mcomp_pkg
// Shared types, constants and the arctangent table of the compass heading block.
// ============================================================================
package mcomp_pkg;

    // Configuration port geometry and register indexes.
    localparam int ADDR_W = 5;
    localparam int IDX_W  = 3;
    localparam logic [IDX_W-1:0] REG_LSB_RES = 3'd0;
    localparam logic [IDX_W-1:0] REG_ASA_X   = 3'd1;
    localparam logic [IDX_W-1:0] REG_ASA_Y   = 3'd2;
    localparam logic [IDX_W-1:0] REG_BIAS_X  = 3'd3;
    localparam logic [IDX_W-1:0] REG_BIAS_Y  = 3'd4;

    localparam logic [15:0] RES_RESET = 16'd24576;
    localparam logic [7:0]  ASA_RESET = 8'd128;

    // Datapath widths.
    localparam int CNT_W    = 16;
    localparam int P1_W     = 33;   // count * lsb_res
    localparam int P2_W     = 43;   // times (asa + 128)
    localparam int SCALE_SH = 18;
    localparam int AX_W     = 26;   // scaled axis minus bias
    localparam int CW       = 36;   // CORDIC vector components
    localparam int ZW       = 24;   // CORDIC angle, 2^-14 degree units
    localparam int TW       = 25;   // angle before rounding to 1/64 degree
    localparam int HR_W     = 17;   // rounded heading before wrapping
    localparam int HEAD_W   = 15;

    // CORDIC iteration count, limited to the table length.
    localparam int CORDIC_STEPS = 16;
    localparam int TABLE_LEN    = 24;
    localparam int ITER_COUNT   = (CORDIC_STEPS < TABLE_LEN) ? CORDIC_STEPS : TABLE_LEN;
    localparam int STEP_W       = $clog2(TABLE_LEN);

    localparam logic signed [TW-1:0]   ANG_90    = 25'sd1474560;
    localparam logic signed [TW-1:0]   ANG_270   = 25'sd4423680;
    localparam logic signed [TW-1:0]   ROUND_HALF = 25'sd128;
    localparam logic signed [HR_W-1:0] FULL_CIRCLE = 17'sd23040;
    localparam logic signed [HR_W-1:0] HALF_CIRCLE = 17'sd11520;

    typedef struct packed {
        logic [15:0]        lsb_res;
        logic [7:0]         asa_x;
        logic [7:0]         asa_y;
        logic signed [15:0] bias_x;
        logic signed [15:0] bias_y;
    } cfg_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic              load;
        logic              mul1;
        logic              mul2;
        logic              scale;
        logic              setup;
        logic              iter;
        logic              round;
        logic              write;
        logic [STEP_W-1:0] step;
    } cmd_t;

    typedef struct packed {
        logic out_busy;
    } status_t;

    // atan(2^-i) in units of 2^-14 degree.
    function automatic logic signed [ZW-1:0] atan_angle(input logic [STEP_W-1:0] i);
        logic signed [ZW-1:0] r;
        begin
            case (i)
                5'd0:    r = 24'sd737280;
                5'd1:    r = 24'sd435242;
                5'd2:    r = 24'sd229970;
                5'd3:    r = 24'sd116736;
                5'd4:    r = 24'sd58595;
                5'd5:    r = 24'sd29326;
                5'd6:    r = 24'sd14667;
                5'd7:    r = 24'sd7334;
                5'd8:    r = 24'sd3667;
                5'd9:    r = 24'sd1833;
                5'd10:   r = 24'sd917;
                5'd11:   r = 24'sd458;
                5'd12:   r = 24'sd229;
                5'd13:   r = 24'sd115;
                5'd14:   r = 24'sd57;
                5'd15:   r = 24'sd29;
                5'd16:   r = 24'sd14;
                5'd17:   r = 24'sd7;
                5'd18:   r = 24'sd4;
                5'd19:   r = 24'sd2;
                5'd20:   r = 24'sd1;
                default: r = 24'sd0;
            endcase
            return r;
        end
    endfunction

endpackage

FILE: sv/mcomp_cfg_regs.sv
`timescale 1ns / 1ps
// ============================================================================
// mcomp_cfg_regs
// Register bank behind the configuration port.
// ============================================================================
module mcomp_cfg_regs (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [mcomp_pkg::ADDR_W-1:0] paddr,
    input  logic [31:0]                  pwdata,
    output logic [31:0]                  prdata,
    output logic                         pready,
    output mcomp_pkg::cfg_t              cfg
);

    mcomp_pkg::cfg_t             cfg_reg;
    logic [mcomp_pkg::IDX_W-1:0] idx;
    logic                        wr_en;

    assign pready = 1'b1;
    assign idx    = paddr[mcomp_pkg::ADDR_W-1:2];
    assign wr_en  = psel & penable & pwrite;
    assign cfg    = cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.lsb_res <= mcomp_pkg::RES_RESET;
            cfg_reg.asa_x   <= mcomp_pkg::ASA_RESET;
            cfg_reg.asa_y   <= mcomp_pkg::ASA_RESET;
            cfg_reg.bias_x  <= '0;
            cfg_reg.bias_y  <= '0;
        end
        else if (wr_en)
        begin
            case (idx)
                mcomp_pkg::REG_LSB_RES: cfg_reg.lsb_res <= pwdata[15:0];
                mcomp_pkg::REG_ASA_X:   cfg_reg.asa_x   <= pwdata[7:0];
                mcomp_pkg::REG_ASA_Y:   cfg_reg.asa_y   <= pwdata[7:0];
                mcomp_pkg::REG_BIAS_X:  cfg_reg.bias_x  <= $signed(pwdata[15:0]);
                mcomp_pkg::REG_BIAS_Y:  cfg_reg.bias_y  <= $signed(pwdata[15:0]);
                default:                ;
            endcase
        end
    end

    always_comb
    begin
        case (idx)
            mcomp_pkg::REG_LSB_RES: prdata = {16'd0, cfg_reg.lsb_res};
            mcomp_pkg::REG_ASA_X:   prdata = {24'd0, cfg_reg.asa_x};
            mcomp_pkg::REG_ASA_Y:   prdata = {24'd0, cfg_reg.asa_y};
            mcomp_pkg::REG_BIAS_X:  prdata = {16'd0, cfg_reg.bias_x};
            mcomp_pkg::REG_BIAS_Y:  prdata = {16'd0, cfg_reg.bias_y};
            default:                prdata = 32'd0;
        endcase
    end

endmodule

FILE: sv/mcomp_ctrl.sv
`timescale 1ns / 1ps
// ============================================================================
// mcomp_ctrl
// Sequencer that steps one sample through scaling, CORDIC and rounding.
// ============================================================================
module mcomp_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               s_tvalid,
    output logic               s_tready,
    input  mcomp_pkg::status_t status,
    output mcomp_pkg::cmd_t    cmd
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_MUL1,
        S_MUL2,
        S_SCALE,
        S_SETUP,
        S_ITER,
        S_ROUND,
        S_WRITE
    } state_t;

    state_t                       state_reg;
    logic [mcomp_pkg::STEP_W-1:0] step_reg;
    logic                         last_step;

    assign last_step = (step_reg == mcomp_pkg::STEP_W'(mcomp_pkg::ITER_COUNT - 1));
    assign s_tready  = (state_reg == S_IDLE);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            step_reg  <= '0;
        end
        else
        begin
            case (state_reg)
                S_IDLE:
                begin
                    if (s_tvalid)
                    begin
                        state_reg <= S_MUL1;
                    end
                end
                S_MUL1:  state_reg <= S_MUL2;
                S_MUL2:  state_reg <= S_SCALE;
                S_SCALE: state_reg <= S_SETUP;
                S_SETUP:
                begin
                    step_reg  <= '0;
                    state_reg <= S_ITER;
                end
                S_ITER:
                begin
                    if (last_step)
                    begin
                        step_reg  <= '0;
                        state_reg <= S_ROUND;
                    end
                    else
                    begin
                        step_reg <= step_reg + 1'b1;
                    end
                end
                S_ROUND: state_reg <= S_WRITE;
                S_WRITE:
                begin
                    if (!status.out_busy)
                    begin
                        state_reg <= S_IDLE;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    always_comb
    begin
        cmd       = '0;
        cmd.load  = (state_reg == S_IDLE) & s_tvalid;
        cmd.mul1  = (state_reg == S_MUL1);
        cmd.mul2  = (state_reg == S_MUL2);
        cmd.scale = (state_reg == S_SCALE);
        cmd.setup = (state_reg == S_SETUP);
        cmd.iter  = (state_reg == S_ITER);
        cmd.round = (state_reg == S_ROUND);
        cmd.write = (state_reg == S_WRITE) & ~status.out_busy;
        cmd.step  = step_reg;
    end

    a_step_only_in_iter: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != S_ITER) |-> (step_reg == '0))
        else $error("iteration counter left nonzero outside the CORDIC loop");

    a_accept_starts: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_IDLE && s_tvalid) |=> (state_reg == S_MUL1))
        else $error("accepted request did not start the multiply sequence");

    a_write_returns: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.write |=> (state_reg == S_IDLE))
        else $error("sequencer did not return to idle after writing a result");

endmodule

FILE: sv/mcomp_datapath.sv
`timescale 1ns / 1ps
// ============================================================================
// mcomp_datapath
// Axis scaling multipliers, shift-add CORDIC, rounding and output register.
// ============================================================================
module mcomp_datapath (
    input  logic                clk,
    input  logic                rst_n,
    input  mcomp_pkg::cfg_t     cfg,
    input  mcomp_pkg::cmd_t     cmd,
    output mcomp_pkg::status_t  status,
    input  logic [31:0]         s_tdata,
    input  logic                s_tuser,
    output logic                m_tvalid,
    input  logic                m_tready,
    output logic [15:0]         m_tdata,
    output logic                m_tuser
);

    logic signed [mcomp_pkg::CNT_W-1:0]  kept_x_reg, kept_y_reg;
    logic                                stale_reg;
    logic signed [mcomp_pkg::P1_W-1:0]   p1x_reg, p1y_reg;
    logic signed [mcomp_pkg::P2_W-1:0]   p2x_reg, p2y_reg;
    logic signed [mcomp_pkg::AX_W-1:0]   ax_reg, ay_reg;
    logic signed [mcomp_pkg::CW-1:0]     a_reg, b_reg, a_next, b_next;
    logic signed [mcomp_pkg::ZW-1:0]     z_reg, z_next;
    logic                                yzero_reg, xneg_reg, ypos_reg;
    logic signed [mcomp_pkg::HR_W-1:0]   hr_reg;
    logic                                out_valid_reg;
    logic [mcomp_pkg::HEAD_W-1:0]        heading_reg, heading_next;
    logic                                stale_out_reg;

    logic [8:0]                          gain_x, gain_y;
    logic signed [mcomp_pkg::AX_W-1:0]   x_next, y_next;
    logic signed [mcomp_pkg::CW-1:0]     ya_ext, xb_ext, da, db;
    logic signed [mcomp_pkg::ZW-1:0]     dz;
    logic signed [mcomp_pkg::TW-1:0]     base, t_sum;
    logic signed [mcomp_pkg::HR_W-1:0]   hr_next;

    assign gain_x = {1'b0, cfg.asa_x} + 9'd128;
    assign gain_y = {1'b0, cfg.asa_y} + 9'd128;

    // Floor shift by 18, then subtract the hard-iron bias.
    assign x_next = mcomp_pkg::AX_W'($signed(p2x_reg[mcomp_pkg::P2_W-1:mcomp_pkg::SCALE_SH]))
                  - mcomp_pkg::AX_W'(cfg.bias_x);
    assign y_next = mcomp_pkg::AX_W'($signed(p2y_reg[mcomp_pkg::P2_W-1:mcomp_pkg::SCALE_SH]))
                  - mcomp_pkg::AX_W'(cfg.bias_y);

    // Fold the vector into the right half plane and scale by 256.
    always_comb
    begin
        if (!ay_reg[mcomp_pkg::AX_W-1])
        begin
            ya_ext = mcomp_pkg::CW'(ay_reg) <<< 8;
            xb_ext = mcomp_pkg::CW'(ax_reg) <<< 8;
        end
        else
        begin
            ya_ext = (-mcomp_pkg::CW'(ay_reg)) <<< 8;
            xb_ext = (-mcomp_pkg::CW'(ax_reg)) <<< 8;
        end
    end

    // One vectoring micro-rotation.
    assign da = b_reg >>> cmd.step;
    assign db = a_reg >>> cmd.step;
    assign dz = mcomp_pkg::atan_angle(cmd.step);

    always_comb
    begin
        if (b_reg > 0)
        begin
            a_next = a_reg + da;
            b_next = b_reg - db;
            z_next = z_reg + dz;
        end
        else
        begin
            a_next = a_reg - da;
            b_next = b_reg + db;
            z_next = z_reg - dz;
        end
    end

    assign base  = ypos_reg ? mcomp_pkg::ANG_90 : mcomp_pkg::ANG_270;
    assign t_sum = base - mcomp_pkg::TW'(z_reg) + mcomp_pkg::ROUND_HALF;

    always_comb
    begin
        if (yzero_reg)
        begin
            hr_next = xneg_reg ? mcomp_pkg::HALF_CIRCLE : '0;
        end
        else
        begin
            hr_next = t_sum[mcomp_pkg::TW-1:8];
        end
    end

    always_comb
    begin
        if (hr_reg < 0)
        begin
            heading_next = mcomp_pkg::HEAD_W'(hr_reg + mcomp_pkg::FULL_CIRCLE);
        end
        else if (hr_reg >= mcomp_pkg::FULL_CIRCLE)
        begin
            heading_next = mcomp_pkg::HEAD_W'(hr_reg - mcomp_pkg::FULL_CIRCLE);
        end
        else
        begin
            heading_next = mcomp_pkg::HEAD_W'(hr_reg);
        end
    end

    // Stored counts and output handshake state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            kept_x_reg    <= '0;
            kept_y_reg    <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.load && !s_tuser)
            begin
                kept_x_reg <= $signed(s_tdata[15:0]);
                kept_y_reg <= $signed(s_tdata[31:16]);
            end
            if (cmd.write)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            stale_reg <= s_tuser;
        end
        if (cmd.mul1)
        begin
            p1x_reg <= kept_x_reg * $signed({1'b0, cfg.lsb_res});
            p1y_reg <= kept_y_reg * $signed({1'b0, cfg.lsb_res});
        end
        if (cmd.mul2)
        begin
            p2x_reg <= p1x_reg * $signed({1'b0, gain_x});
            p2y_reg <= p1y_reg * $signed({1'b0, gain_y});
        end
        if (cmd.scale)
        begin
            ax_reg <= x_next;
            ay_reg <= y_next;
        end
        if (cmd.setup)
        begin
            a_reg     <= ya_ext;
            b_reg     <= xb_ext;
            z_reg     <= '0;
            yzero_reg <= (ay_reg == '0);
            xneg_reg  <= ax_reg[mcomp_pkg::AX_W-1];
            ypos_reg  <= ~ay_reg[mcomp_pkg::AX_W-1];
        end
        if (cmd.iter)
        begin
            a_reg <= a_next;
            b_reg <= b_next;
            z_reg <= z_next;
        end
        if (cmd.round)
        begin
            hr_reg <= hr_next;
        end
        if (cmd.write)
        begin
            heading_reg   <= heading_next;
            stale_out_reg <= stale_reg;
        end
    end

    assign status.out_busy = out_valid_reg & ~m_tready;
    assign m_tvalid        = out_valid_reg;
    assign m_tdata         = {1'b0, heading_reg};
    assign m_tuser         = stale_out_reg;

    a_heading_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (heading_reg < 15'd23040))
        else $error("heading outside one full turn");

endmodule

FILE: sv/magnetometer_compass_heading.sv
`timescale 1ns / 1ps
// A result becomes valid after its request passes the multiply, scaling, setup, CORDIC,
// rounding and write states. Only one request is in flight at a time, set by the single
//   iterative CORDIC unit that performs one micro-rotation per cycle.
// A finished result waits in the output register; a new request is accepted meanwhile.
// Reset (rst_n, asynchronous, active low) restores default registers and zero stored counts.
// ============================================================================
// magnetometer_compass_heading
// Scales raw X/Y magnetometer counts to milligauss and returns a compass heading.
// ============================================================================
module magnetometer_compass_heading (
    input  logic                         clk,
    input  logic                         rst_n,
    // Sample stream.
    input  logic                         s_tvalid,
    output logic                         s_tready,
    input  logic [31:0]                  s_tdata,   // [15:0] count_x, [31:16] count_y
    input  logic                         s_tuser,   // [0] overflow
    // Heading stream.
    output logic                         m_tvalid,
    input  logic                         m_tready,
    output logic [15:0]                  m_tdata,   // [14:0] heading, [15] zero
    output logic                         m_tuser,   // [0] stale
    // Configuration port.
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [mcomp_pkg::ADDR_W-1:0] paddr,
    input  logic [31:0]                  pwdata,
    output logic [31:0]                  prdata,
    output logic                         pready
);

    // The register bank feeds the scaling multipliers directly, with no shadow copy. Writes
    // must be made only while the block is idle; the block itself does not enforce this.
    mcomp_pkg::cfg_t    cfg;
    mcomp_pkg::cmd_t    cmd;
    mcomp_pkg::status_t status;

    mcomp_cfg_regs u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    // The controller walks each request through load, the MUL1 and MUL2 multiply
    // states, bias subtraction, CORDIC setup, the micro-rotations, rounding and
    // the output write. The write waits only while the previous result is unclaimed.
    mcomp_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .status   (status),
        .cmd      (cmd)
    );

    // The datapath keeps the last good counts. When a request flags overflow the
    // counts it carries are dropped and the kept ones are used, and the result is
    // marked stale. A zero Y axis bypasses the CORDIC angle and gives north or
    // south from the sign of X.
    mcomp_datapath u_dp (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg      (cfg),
        .cmd      (cmd),
        .status   (status),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

endmodule

FILE: tb/compass_checker.sv
`timescale 1ns / 1ps
// ============================================================================
// compass_checker
// Watches the sample, heading and configuration channels of the compass
// block, predicts every heading and compares each one as it leaves the block.
// ============================================================================
module compass_checker (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         s_tvalid,
    input  logic                         s_tready,
    input  logic [31:0]                  s_tdata,   // [15:0] count_x, [31:16] count_y
    input  logic                         s_tuser,   // [0] overflow
    input  logic                         m_tvalid,
    input  logic                         m_tready,
    input  logic [15:0]                  m_tdata,   // [14:0] heading, [15] zero
    input  logic                         m_tuser,   // [0] stale
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [mcomp_pkg::ADDR_W-1:0] paddr,
    input  logic [31:0]                  pwdata,
    input  logic [31:0]                  prdata,
    input  logic                         pready,
    output int                           pending,
    output int                           errors
);
    import mcomp_pkg::*;

    typedef struct packed {
        logic [HEAD_W-1:0] heading;
        logic              stale;
    } heading_rec_t;

    localparam int     STEPS      = CORDIC_STEPS;
    localparam int     ATAN_LEN   = 24;
    localparam longint ONE_DEG    = 16384;
    localparam longint CIRCLE_64  = 23040;
    localparam longint HALF_64    = 11520;

    // atan(2^-i) in 2^-14 degree units.
    longint atan_step [0:ATAN_LEN-1] = '{
        737280, 435242, 229970, 116736, 58595, 29326, 14667, 7334,
        3667, 1833, 917, 458, 229, 115, 57, 29,
        14, 7, 4, 2, 1, 0, 0, 0
    };

    // Shadow of the register file and of the stored counts.
    logic [15:0]        res_q;
    logic [7:0]         asa_x_q;
    logic [7:0]         asa_y_q;
    logic signed [15:0] bias_x_q;
    logic signed [15:0] bias_y_q;
    logic signed [15:0] kept_x_q;
    logic signed [15:0] kept_y_q;

    heading_rec_t heading_due_q[$];
    heading_rec_t due;
    int           fails;

    // Counts to milligauss with 4 fraction bits, floor division, minus bias.
    function automatic longint field_mg(input logic signed [15:0] cnt,
                                        input logic [7:0] asa,
                                        input logic signed [15:0] bias);
        longint c;
        longint r;
        longint g;
        longint b;
        c = cnt;
        r = res_q;
        g = asa;
        b = bias;
        return ((c * r * (g + 128)) >>> 18) - b;
    endfunction

    // Vectoring CORDIC: returns atan(b / a) for a > 0.
    function automatic longint vector_angle(input longint a0, input longint b0);
        longint a;
        longint b;
        longint z;
        longint da;
        longint db;
        a = a0;
        b = b0;
        z = 0;
        for (int i = 0; i < STEPS && i < ATAN_LEN; i++) begin
            da = b >>> i;
            db = a >>> i;
            if (b > 0) begin
                a = a + da;
                b = b - db;
                z = z + atan_step[i];
            end else begin
                a = a - da;
                b = b + db;
                z = z - atan_step[i];
            end
        end
        return z;
    endfunction

    function automatic heading_rec_t compass_heading(input logic ovf);
        heading_rec_t rec;
        longint x;
        longint y;
        longint z;
        longint base;
        longint h;
        x = field_mg(kept_x_q, asa_x_q, bias_x_q);
        y = field_mg(kept_y_q, asa_y_q, bias_y_q);
        if (y == 0) begin
            h = (x < 0) ? HALF_64 : 0;
        end else begin
            if (y > 0) begin
                z    = vector_angle(y * 256, x * 256);
                base = 90 * ONE_DEG;
            end else begin
                z    = vector_angle(-y * 256, -x * 256);
                base = 270 * ONE_DEG;
            end
            h = (base - z + 128) >>> 8;
            if (h < 0)
                h = h + CIRCLE_64;
            if (h >= CIRCLE_64)
                h = h - CIRCLE_64;
        end
        rec.heading = h[HEAD_W-1:0];
        rec.stale   = ovf;
        return rec;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            res_q    = RES_RESET;
            asa_x_q  = ASA_RESET;
            asa_y_q  = ASA_RESET;
            bias_x_q = '0;
            bias_y_q = '0;
            kept_x_q = '0;
            kept_y_q = '0;
            heading_due_q.delete();
            fails    = 0;
            pending <= 0;
            errors  <= 0;
        end else begin
            // Retire first: a heading can never belong to a request of this edge.
            if (m_tvalid && m_tready) begin
                if (heading_due_q.size() == 0) begin
                    $error("heading %0d arrived with no request outstanding", m_tdata[14:0]);
                    fails++;
                end else begin
                    due = heading_due_q.pop_front();
                    if (m_tdata[HEAD_W-1:0] !== due.heading) begin
                        $error("heading mismatch: expected %0d, actual %0d",
                               due.heading, m_tdata[HEAD_W-1:0]);
                        fails++;
                    end
                    if (m_tuser !== due.stale) begin
                        $error("stale mismatch: expected %0d, actual %0d", due.stale, m_tuser);
                        fails++;
                    end
                end
            end

            if (s_tvalid && s_tready) begin
                if (!s_tuser) begin
                    kept_x_q = s_tdata[15:0];
                    kept_y_q = s_tdata[31:16];
                end
                heading_due_q.push_back(compass_heading(s_tuser));
            end

            if (psel && penable && pready) begin
                if (pwrite) begin
                    case (paddr[ADDR_W-1:2])
                        REG_LSB_RES: res_q    = pwdata[15:0];
                        REG_ASA_X:   asa_x_q  = pwdata[7:0];
                        REG_ASA_Y:   asa_y_q  = pwdata[7:0];
                        REG_BIAS_X:  bias_x_q = pwdata[15:0];
                        REG_BIAS_Y:  bias_y_q = pwdata[15:0];
                        default: ;
                    endcase
                end else begin
                    case (paddr[ADDR_W-1:2])
                        REG_LSB_RES:
                            if (prdata[15:0] !== res_q) begin
                                $error("lsb_res mismatch: expected %0d, actual %0d",
                                       res_q, prdata[15:0]);
                                fails++;
                            end
                        REG_ASA_X:
                            if (prdata[7:0] !== asa_x_q) begin
                                $error("asa_x mismatch: expected %0d, actual %0d",
                                       asa_x_q, prdata[7:0]);
                                fails++;
                            end
                        REG_ASA_Y:
                            if (prdata[7:0] !== asa_y_q) begin
                                $error("asa_y mismatch: expected %0d, actual %0d",
                                       asa_y_q, prdata[7:0]);
                                fails++;
                            end
                        REG_BIAS_X:
                            if (prdata[15:0] !== bias_x_q) begin
                                $error("bias_x mismatch: expected %0d, actual %0d",
                                       bias_x_q, $signed(prdata[15:0]));
                                fails++;
                            end
                        REG_BIAS_Y:
                            if (prdata[15:0] !== bias_y_q) begin
                                $error("bias_y mismatch: expected %0d, actual %0d",
                                       bias_y_q, $signed(prdata[15:0]));
                                fails++;
                            end
                        default: ;
                    endcase
                end
            end

            pending <= heading_due_q.size();
            errors  <= fails;
        end
    end

endmodule

FILE: tb/tb_top.sv
`timescale 1ns / 1ps
// ============================================================================
// tb_top
// Drives samples and register settings into the compass heading block and
// lets the checker judge every heading; prints the verdict at the end.
// ============================================================================
module tb_top;
    import mcomp_pkg::*;

    // Index with no register behind it; writes there must change nothing.
    localparam logic [IDX_W-1:0] REG_UNUSED = 3'd5;

    // Long enough for the block to fill its output register and its CORDIC
    // and then refuse further requests on the sample side.
    localparam int HOLD_CYCLES   = 400;
    localparam int PHASE_ITEMS   = 72;
    localparam int RANDOM_PHASES = 6;

    logic                clk;
    logic                rst_n;
    logic                s_tvalid;
    logic                s_tready;
    logic [31:0]         s_tdata;
    logic                s_tuser;
    logic                m_tvalid;
    logic                m_tready;
    logic [15:0]         m_tdata;
    logic                m_tuser;
    logic                psel;
    logic                penable;
    logic                pwrite;
    logic [ADDR_W-1:0]   paddr;
    logic [31:0]         pwdata;
    logic [31:0]         prdata;
    logic                pready;

    int   pending;
    int   errors;

    // When calm is set neither side inserts idle cycles.
    logic calm;
    // Raised by the stimulus to make the heading side hold off for a long stretch.
    logic hold_off_go;

    magnetometer_compass_heading dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    compass_checker u_checker (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready),
        .pending  (pending),
        .errors   (errors)
    );

    initial clk = 1'b0;
    always #4 clk = ~clk;

    // Idle lengths: mostly none or short, now and then a long gap.
    function automatic int idle_len();
        int r;
        if (calm)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // Offer one sample request and return at the edge where it is taken.
    task automatic send_sample(input logic [15:0] cx, input logic [15:0] cy,
                               input logic ovf);
        int gap;
        gap = idle_len();
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {cy, cx};
        s_tuser  <= ovf;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
    endtask

    // Stop offering and wait until every heading owed has come out. The first
    // edge lets the checker count the request accepted at this very edge.
    task automatic drain();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
    endtask

    task automatic reg_write(input logic [IDX_W-1:0] idx, input logic [31:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge clk);
    endtask

    // The checker compares prdata on the access edge.
    task automatic reg_read(input logic [IDX_W-1:0] idx);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= {idx, 2'b00};
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge clk);
    endtask

    task automatic set_calibration(input logic [15:0] res, input logic [7:0] ax,
                                   input logic [7:0] ay, input logic signed [15:0] bx,
                                   input logic signed [15:0] by);
        reg_write(REG_LSB_RES, {16'h0, res});
        reg_write(REG_ASA_X, {24'h0, ax});
        reg_write(REG_ASA_Y, {24'h0, ay});
        reg_write(REG_BIAS_X, {{16{bx[15]}}, bx});
        reg_write(REG_BIAS_Y, {{16{by[15]}}, by});
        reg_read(REG_LSB_RES);
        reg_read(REG_ASA_X);
        reg_read(REG_ASA_Y);
        reg_read(REG_BIAS_X);
        reg_read(REG_BIAS_Y);
    endtask

    // Mostly full-range counts, with small values and zero axes mixed in so
    // that the y-equals-zero branch and headings near the axes come up often.
    task automatic send_random_sample();
        logic [15:0] cx;
        logic [15:0] cy;
        int          pick;
        int          t;
        cx   = 16'($urandom);
        cy   = 16'($urandom);
        pick = $urandom_range(0, 99);
        if (pick < 15) begin
            t  = $urandom_range(0, 128);
            cx = 16'(t - 64);
            t  = $urandom_range(0, 128);
            cy = 16'(t - 64);
        end else if (pick < 25) begin
            cy = '0;
        end else if (pick < 30) begin
            cx = '0;
        end
        send_sample(cx, cy, $urandom_range(0, 99) < 15);
    endtask

    function automatic logic [15:0] random_bias();
        int t;
        if ($urandom_range(0, 2) == 0)
            return 16'($urandom);
        t = $urandom_range(0, 3000);
        return 16'(t - 1500);
    endfunction

    // Heading side: random ready with stalls, or a long hold-off on request.
    initial
    begin
        int n;
        int held;
        m_tready <= 1'b0;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever begin
            if (hold_off_go) begin
                m_tready <= 1'b0;
                for (held = 0; held < HOLD_CYCLES; held++)
                    @(posedge clk);
                hold_off_go = 1'b0;
            end else begin
                n = idle_len();
                if (n > 0) begin
                    m_tready <= 1'b0;
                    repeat (n) @(posedge clk);
                end
                m_tready <= 1'b1;
                repeat ($urandom_range(1, 12)) @(posedge clk);
            end
        end
    end

    // Main stimulus.
    initial
    begin
        calm        = 1'b0;
        hold_off_go = 1'b0;
        rst_n       = 1'b0;
        s_tvalid    <= 1'b0;
        s_tdata     <= '0;
        s_tuser     <= 1'b0;
        psel        <= 1'b0;
        penable     <= 1'b0;
        pwrite      <= 1'b0;
        paddr       <= '0;
        pwdata      <= '0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part, default calibration (24 mG/16 per count on both axes).
        // An overflow straight after reset reuses the zero counts: heading 0.
        send_sample(16'h1234, 16'h5678, 1'b1);
        send_sample(16'h0000, 16'h0000, 1'b0);
        // y zero: south when x is negative, north otherwise.
        send_sample(16'hfffb, 16'h0000, 1'b0);
        send_sample(16'h0005, 16'h0000, 1'b0);
        // Pure east and west.
        send_sample(16'h0000, 16'h0064, 1'b0);
        send_sample(16'h0000, 16'hff9c, 1'b0);
        // Count extremes in all four quadrants.
        send_sample(16'h7fff, 16'h7fff, 1'b0);
        send_sample(16'h8000, 16'h8000, 1'b0);
        send_sample(16'h7fff, 16'h8000, 1'b0);
        send_sample(16'h8000, 16'h7fff, 1'b0);
        // Nearly along the x axis: the first two round to or across the wrap point.
        send_sample(16'h7fff, 16'hffff, 1'b0);
        send_sample(16'h7fff, 16'h0001, 1'b0);
        send_sample(16'h8001, 16'h0001, 1'b0);
        send_sample(16'h8001, 16'hffff, 1'b0);
        // Overflow after a good sample: the stored counts come back.
        send_sample(16'h5555, 16'haaaa, 1'b0);
        send_sample(16'h0f0f, 16'hf0f0, 1'b1);
        send_sample(16'haaaa, 16'h5555, 1'b0);
        send_sample(16'h0000, 16'h0000, 1'b1);
        drain();

        // Random phases, the first three with the register extremes.
        for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
            drain();
            case (ph)
                0: begin
                    reg_write(REG_UNUSED, 32'hffff_ffff);
                    set_calibration(16'hffff, 8'hff, 8'hff, 16'sd0, 16'sd0);
                end
                1: set_calibration(16'h0000, 8'h00, 8'h00, -16'sd32768, 16'sd32767);
                2: set_calibration(16'h4000, 8'h00, 8'hff, 16'sd32767, -16'sd32768);
                default: set_calibration(16'($urandom), 8'($urandom), 8'($urandom),
                                         random_bias(), random_bias());
            endcase
            calm = (ph == 4);
            for (int k = 0; k < PHASE_ITEMS; k++) begin
                // Once, let the heading side stall while requests keep coming.
                if (ph == 3 && k == 10)
                    hold_off_go = 1'b1;
                // Once, pause the samples mid-phase until all headings are out.
                if (ph == 5 && k == 30)
                    drain();
                send_random_sample();
            end
            calm = 1'b0;
        end

        drain();
        repeat (60) @(posedge clk);
        if (errors == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

    // Watchdog: far beyond the slowest correct run.
    initial
    begin
        #4_000_000;
        $display("DONE: errors detected");
        $finish;
    end

endmodule

FILE: sim.f
sv/mcomp_pkg.sv
sv/mcomp_cfg_regs.sv
sv/mcomp_ctrl.sv
sv/mcomp_datapath.sv
sv/magnetometer_compass_heading.sv
tb/compass_checker.sv
tb/tb_top.sv
